// File: src/cnms_pkg.sv
// cnms_pkg: shared types, constants and the gradient direction classifier
// for the non-maximum suppression block. Depends on nothing.

package cnms_pkg;

  localparam int MAG_W   = 15;
  localparam int GRAD_W  = 15;
  localparam int IMG_W_W = 12;
  localparam int THR_W   = 15;
  localparam int CFG_W   = 15;

  localparam int IMG_W_RESET = 640;
  localparam int THR_RESET   = 1;

  // tan(pi/8) and tan(3pi/8), unsigned with 16 fraction bits
  localparam int                FRAC_BITS    = 16;
  localparam logic [14:0]       TAN_PI8_Q16  = 15'd27145;
  localparam logic [17:0]       TAN_3PI8_Q16 = 18'd158217;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH   = 1'b0,
    REG_LOW_THRESHOLD = 1'b1
  } reg_idx_t;

  // quantised gradient direction of one pixel
  typedef enum logic [1:0] {
    DIR_HORZ      = 2'd0,
    DIR_DIAG_UP   = 2'd1, // bottom-left / top-right neighbours
    DIR_DIAG_DOWN = 2'd2, // top-left / bottom-right neighbours
    DIR_VERT      = 2'd3
  } dir_t;

  // one line buffer entry: direction of the previous row, magnitudes of the
  // previous row and of the row before it
  typedef struct packed {
    dir_t             dir;
    logic [MAG_W-1:0] row_prev;
    logic [MAG_W-1:0] row_old;
  } line_t;

  // classified request handed from front to back
  typedef struct packed {
    logic             test;
    logic [MAG_W-1:0] center;
    logic [MAG_W-1:0] n0;
    logic [MAG_W-1:0] n1;
  } job_t;

  function automatic dir_t classify(input logic [GRAD_W-1:0] gx,
                                    input logic [GRAD_W-1:0] gy);
    logic [GRAD_W-1:0] ax;
    logic [GRAD_W-1:0] ay;
    logic [32:0]       ay_sh;
    logic [32:0]       lo;
    logic [32:0]       hi;
    dir_t              d;
    ax    = gx[GRAD_W-1] ? (~gx + GRAD_W'(1)) : gx;
    ay    = gy[GRAD_W-1] ? (~gy + GRAD_W'(1)) : gy;
    ay_sh = 33'(ay) << FRAC_BITS;
    lo    = 33'(ax) * 33'(TAN_PI8_Q16);
    hi    = 33'(ax) * 33'(TAN_3PI8_Q16);
    if (ay_sh < lo) begin
      d = DIR_HORZ;
    end else if (ay_sh < hi) begin
      d = (gx[GRAD_W-1] ^ gy[GRAD_W-1]) ? DIR_DIAG_UP : DIR_DIAG_DOWN;
    end else begin
      d = DIR_VERT;
    end
    return d;
  endfunction

endpackage

// File: src/cnms_ram.sv
// cnms_ram: generic simple dual-port ram, one write and one registered read
// port. No dependencies.

module cnms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/cnms_front.sv
// cnms_front: configuration registers, raster counters, line buffer, 3x3
// window and direction classification. Uses cnms_pkg and cnms_ram.

module cnms_front #(
  parameter int MAX_WIDTH   = 2048,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  cnms_pkg::reg_idx_t               cfg_index,
  input  logic [cnms_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             push,
  output logic                             full,
  input  logic                             start_of_frame,
  input  logic [cnms_pkg::MAG_W-1:0]       grad_mag,
  input  logic [cnms_pkg::GRAD_W-1:0]      grad_x,
  input  logic [cnms_pkg::GRAD_W-1:0]      grad_y,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count,
  output logic                             job_push,
  output cnms_pkg::job_t                   job
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int EW  = (WW > cnms_pkg::IMG_W_W) ? WW : cnms_pkg::IMG_W_W;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int LW  = $bits(cnms_pkg::line_t);
  localparam int WIDTH_RESET = (cnms_pkg::IMG_W_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                   : cnms_pkg::IMG_W_RESET;
  localparam logic [1:0] ROW_FULL = 2'd2;

  logic [WW-1:0]                width_eff;
  logic [cnms_pkg::THR_W-1:0]   low_thr;
  logic [WW-1:0]                width_wr;
  logic [EW-1:0]                cfg_ext;

  logic [CW-1:0]                col_count;
  logic [1:0]                   row_count;
  logic [CW-1:0]                cc;
  logic [1:0]                   rc;
  logic [WW-1:0]                cc_inc;
  logic                         accept;
  logic                         produce;

  logic                         s1_valid;
  logic                         s1_prod;
  logic [CW-1:0]                s1_col;
  logic [cnms_pkg::MAG_W-1:0]   s1_mag;
  logic [cnms_pkg::GRAD_W-1:0]  s1_gx;
  logic [cnms_pkg::GRAD_W-1:0]  s1_gy;

  logic [LW-1:0]                ram_rdata;
  cnms_pkg::line_t              line_rd;
  cnms_pkg::line_t              line_wr;
  logic                         byp_hit;
  cnms_pkg::line_t              byp_data;

  logic [cnms_pkg::MAG_W-1:0]   win [9];
  cnms_pkg::dir_t               dir_hold;

  // configuration, width clamped to the supported range on write
  always_comb begin
    cfg_ext = EW'(cfg_data[cnms_pkg::IMG_W_W-1:0]);
    if (cfg_ext < EW'(3)) begin
      width_wr = WW'(3);
    end else if (cfg_ext > EW'(MAX_WIDTH)) begin
      width_wr = WW'(MAX_WIDTH);
    end else begin
      width_wr = WW'(cfg_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff <= WW'(WIDTH_RESET);
      low_thr   <= cnms_pkg::THR_W'(cnms_pkg::THR_RESET);
    end else if (cfg_write) begin
      unique case (cfg_index)
        cnms_pkg::REG_IMAGE_WIDTH:   width_eff <= width_wr;
        cnms_pkg::REG_LOW_THRESHOLD: low_thr   <= cfg_data[cnms_pkg::THR_W-1:0];
      endcase
    end
  end

  // room for the new request and the one already in flight
  assign full   = ({1'b0, q_count} + (QCW + 1)'(s1_prod)) >= (QCW + 1)'(QUEUE_DEPTH);
  assign accept = push & ~full;

  always_comb begin
    cc      = start_of_frame ? '0 : col_count;
    rc      = start_of_frame ? 2'd0 : row_count;
    cc_inc  = WW'(cc) + WW'(1);
    produce = (rc == ROW_FULL) && (cc >= CW'(2)) && (WW'(cc) < width_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= 2'd0;
      s1_valid  <= 1'b0;
      s1_prod   <= 1'b0;
      byp_hit   <= 1'b0;
    end else begin
      s1_valid <= accept;
      s1_prod  <= accept & produce;
      byp_hit  <= accept & s1_valid & (cc == s1_col);
      if (accept) begin
        if (cc_inc >= width_eff) begin
          col_count <= '0;
          row_count <= (rc == ROW_FULL) ? ROW_FULL : rc + 2'd1;
        end else begin
          col_count <= cc + CW'(1);
          row_count <= rc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    byp_data <= line_wr;
    if (accept) begin
      s1_col <= cc;
      s1_mag <= grad_mag;
      s1_gx  <= grad_x;
      s1_gy  <= grad_y;
    end
  end

  // line buffer: read at acceptance, written back in the following cycle
  assign line_rd = byp_hit ? byp_data : cnms_pkg::line_t'(ram_rdata);

  always_comb begin
    line_wr.dir      = cnms_pkg::classify(s1_gx, s1_gy);
    line_wr.row_prev = s1_mag;
    line_wr.row_old  = line_rd.row_prev;
  end

  cnms_ram #(
    .WIDTH(LW),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (s1_valid),
    .waddr(s1_col),
    .wdata(line_wr),
    .re   (accept),
    .raddr(cc),
    .rdata(ram_rdata)
  );

  // 3x3 window, right column loaded from the line buffer and the new pixel
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      win[0]   <= win[1];
      win[1]   <= win[2];
      win[2]   <= line_rd.row_old;
      win[3]   <= win[4];
      win[4]   <= win[5];
      win[5]   <= line_rd.row_prev;
      win[6]   <= win[7];
      win[7]   <= win[8];
      win[8]   <= s1_mag;
      dir_hold <= line_rd.dir;
    end
  end

  // neighbours taken from the window as it stands before this shift and from the incoming column
  always_comb begin
    job.center = win[5];
    job.test   = win[5] > low_thr;
    unique case (dir_hold)
      cnms_pkg::DIR_HORZ: begin
        job.n0 = win[4];
        job.n1 = line_rd.row_prev;
      end
      cnms_pkg::DIR_DIAG_UP: begin
        job.n0 = win[7];
        job.n1 = line_rd.row_old;
      end
      cnms_pkg::DIR_DIAG_DOWN: begin
        job.n0 = win[1];
        job.n1 = s1_mag;
      end
      cnms_pkg::DIR_VERT: begin
        job.n0 = win[2];
        job.n1 = win[8];
      end
      default: begin
        job.n0 = win[2];
        job.n1 = win[8];
      end
    endcase
  end

  assign job_push = s1_valid & s1_prod;

`ifndef SYNTHESIS
  a_row_sat: assert property (@(posedge clk) disable iff (rst) row_count != 2'd3)
    else $error("row counter passed saturation");
  a_width_range: assert property (@(posedge clk) disable iff (rst)
    (width_eff >= WW'(3)) && (width_eff <= WW'(MAX_WIDTH)))
    else $error("effective width out of range");
`endif

endmodule

// File: src/cnms_queue.sv
// cnms_queue: short register queue of classified requests between front and
// back. Uses cnms_pkg.

module cnms_queue #(
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  cnms_pkg::job_t             wr_job,
  input  logic                       pop,
  output cnms_pkg::job_t             rd_job,
  output logic                       not_empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CNW = $clog2(DEPTH + 1);

  cnms_pkg::job_t entries [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;

  assign not_empty = count != '0;
  assign rd_job    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CNW'(1);
      end else if (pop && !push) begin
        count <= count - CNW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != CNW'(DEPTH)))
    else $error("request queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("request queue underflow");
`endif

endmodule

// File: src/cnms_back.sv
// cnms_back: neighbour compare and suppression, feeding the result register.
// Uses cnms_pkg.

module cnms_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       job_valid,
  input  cnms_pkg::job_t             job,
  output logic                       job_pop,
  input  logic                       pop,
  output logic                       empty,
  output logic [cnms_pkg::MAG_W-1:0] out_mag,
  output logic                       suppressed
);

  logic out_valid;
  logic sup;

  assign sup     = job.test & ((job.n0 > job.center) | (job.n1 > job.center));
  assign job_pop = job_valid & (~out_valid | pop);
  assign empty   = ~out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (job_pop) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      out_mag    <= sup ? '0 : job.center;
      suppressed <= sup;
    end
  end

`ifndef SYNTHESIS
  a_sup_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && suppressed) |-> (out_mag == '0))
    else $error("suppressed result carries a magnitude");
`endif

endmodule

// File: src/canny_nonmax_suppression.sv
// canny_nonmax_suppression: top level of the canny non-maximum suppression
// block. Uses cnms_pkg, cnms_front, cnms_queue and cnms_back.
//
//   channel  direction  handshake           payload
//   pixels   in         push / full         start_of_frame grad_mag grad_x grad_y
//   results  out        empty / pop         out_mag suppressed
//   config   in         cfg_write (no wait) cfg_index cfg_data
//
// one pixel per clock sustained while results are popped and full stays low; a
// result passes the line buffer read and window, then the queue and compare
// border pixels give no result; the line buffer ram needs no clearing pass
// synchronous reset clears counters, queue and result valid, and restores
// the registers to width 640 and threshold 1
// full rises when the request queue and the request in flight fill it

module canny_nonmax_suppression #(
  parameter int MAX_WIDTH   = 2048,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  cnms_pkg::reg_idx_t          cfg_index,
  input  logic [cnms_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        push,
  output logic                        full,
  input  logic                        start_of_frame,
  input  logic [cnms_pkg::MAG_W-1:0]  grad_mag,
  input  logic [cnms_pkg::GRAD_W-1:0] grad_x,
  input  logic [cnms_pkg::GRAD_W-1:0] grad_y,
  output logic                        empty,
  input  logic                        pop,
  output logic [cnms_pkg::MAG_W-1:0]  out_mag,
  output logic                        suppressed
);

  logic                               job_push;
  cnms_pkg::job_t                     job_in;
  cnms_pkg::job_t                     job_out;
  logic                               job_valid;
  logic                               job_pop;
  logic [$clog2(QUEUE_DEPTH+1)-1:0]   q_count;

  cnms_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push),
    .full          (full),
    .start_of_frame(start_of_frame),
    .grad_mag      (grad_mag),
    .grad_x        (grad_x),
    .grad_y        (grad_y),
    .q_count       (q_count),
    .job_push      (job_push),
    .job           (job_in)
  );

  cnms_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .wr_job   (job_in),
    .pop      (job_pop),
    .rd_job   (job_out),
    .not_empty(job_valid),
    .count    (q_count)
  );

  cnms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job_out),
    .job_pop   (job_pop),
    .pop       (pop),
    .empty     (empty),
    .out_mag   (out_mag),
    .suppressed(suppressed)
  );

endmodule

// File: tb/tb.sv
// tb: self-checking bench for canny_nonmax_suppression, with a pixel-level predictor
// of the line buffers, window and direction compare held in a small scoreboard class.
// Depends on cnms_pkg and canny_nonmax_suppression.

module tb;

  localparam int LINE_MAX       = 2048;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int Q_SHIFT        = 16;
  localparam longint unsigned TAN_LO_Q16 = 27145;
  localparam longint unsigned TAN_HI_Q16 = 158217;

  typedef struct {
    logic [cnms_pkg::MAG_W-1:0] mag;
    logic                       sup;
  } nms_result_t;

  class nms_scoreboard;
    logic [11:0]                width_reg;
    logic [cnms_pkg::THR_W-1:0] thr_reg;
    logic [cnms_pkg::MAG_W-1:0] mag_rows[2*LINE_MAX];
    logic [29:0]                grad_row[LINE_MAX];
    logic [cnms_pkg::MAG_W-1:0] win[9];
    logic [29:0]                grad_hold;
    int unsigned                col_cnt;
    int unsigned                rows_done;
    nms_result_t                expected_q[$];
    int                         errors;
    int                         checked;
    int                         zeroed;

    function new();
      width_reg = 12'(cnms_pkg::IMG_W_RESET);
      thr_reg   = 15'(cnms_pkg::THR_RESET);
      foreach (mag_rows[i]) mag_rows[i] = '0;
      foreach (grad_row[i]) grad_row[i] = '0;
      foreach (win[i]) win[i] = '0;
      grad_hold = '0;
      col_cnt   = 0;
      rows_done = 0;
      errors    = 0;
      checked   = 0;
      zeroed    = 0;
    endfunction

    function void set_reg(cnms_pkg::reg_idx_t idx, logic [cnms_pkg::CFG_W-1:0] val);
      if (idx == cnms_pkg::REG_IMAGE_WIDTH) width_reg = val[11:0];
      else thr_reg = val[cnms_pkg::THR_W-1:0];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // model one accepted pixel; queue the centre result if it is interior
    function void note_pixel(logic sof, logic [cnms_pkg::MAG_W-1:0] mag,
                             logic [cnms_pkg::GRAD_W-1:0] gx,
                             logic [cnms_pkg::GRAD_W-1:0] gy);
      int unsigned                len;
      int unsigned                col;
      logic [29:0]                centre_grad;
      logic [cnms_pkg::MAG_W-1:0] c;
      logic [cnms_pkg::MAG_W-1:0] n0;
      logic [cnms_pkg::MAG_W-1:0] n1;
      int                         sx;
      int                         sy;
      longint unsigned            ax;
      longint unsigned            ay;
      cnms_pkg::dir_t             dir;
      nms_result_t                r;
      len = (width_reg < 3) ? 3 : ((width_reg > LINE_MAX) ? LINE_MAX : width_reg);
      if (sof) begin
        col_cnt   = 0;
        rows_done = 0;
      end
      col = col_cnt % LINE_MAX;
      win[0] = win[1];
      win[1] = win[2];
      win[3] = win[4];
      win[4] = win[5];
      win[6] = win[7];
      win[7] = win[8];
      win[2] = mag_rows[col];
      win[5] = mag_rows[LINE_MAX + col];
      win[8] = mag;
      centre_grad = grad_hold;
      grad_hold   = grad_row[col];
      if (rows_done >= 2 && col_cnt >= 2 && col_cnt < len) begin
        c     = win[4];
        r.sup = 1'b0;
        if (c > thr_reg) begin
          sx = $signed(centre_grad[14:0]);
          sy = $signed(centre_grad[29:15]);
          ax = (sx < 0) ? -sx : sx;
          ay = (sy < 0) ? -sy : sy;
          ay = ay << Q_SHIFT;
          if (ay < TAN_LO_Q16 * ax) begin
            dir = cnms_pkg::DIR_HORZ;
          end else if (ay < TAN_HI_Q16 * ax) begin
            if ((sx < 0) != (sy < 0)) dir = cnms_pkg::DIR_DIAG_UP;
            else dir = cnms_pkg::DIR_DIAG_DOWN;
          end else begin
            dir = cnms_pkg::DIR_VERT;
          end
          case (dir)
            cnms_pkg::DIR_HORZ: begin
              n0 = win[3];
              n1 = win[5];
            end
            cnms_pkg::DIR_DIAG_UP: begin
              n0 = win[6];
              n1 = win[2];
            end
            cnms_pkg::DIR_DIAG_DOWN: begin
              n0 = win[0];
              n1 = win[8];
            end
            default: begin
              n0 = win[1];
              n1 = win[7];
            end
          endcase
          r.sup = (n0 > c) || (n1 > c);
        end
        r.mag = r.sup ? '0 : c;
        expected_q.insert(expected_q.size(), r);
      end
      mag_rows[col]            = mag_rows[LINE_MAX + col];
      mag_rows[LINE_MAX + col] = mag;
      grad_row[col]            = {gy, gx};
      col_cnt++;
      if (col_cnt >= len) begin
        col_cnt = 0;
        if (rows_done < 2) rows_done++;
      end
    endfunction

    function void check_result(logic [cnms_pkg::MAG_W-1:0] mag, logic sup);
      nms_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, out_mag %0d suppressed %0d",
                 $time, mag, sup);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (mag !== e.mag) begin
        $display("%0t: out_mag expected %0d got %0d", $time, e.mag, mag);
        errors++;
      end
      if (sup !== e.sup) begin
        $display("%0t: suppressed expected %0d got %0d", $time, e.sup, sup);
        errors++;
      end
      if (sup === 1'b1) zeroed++;
    endfunction
  endclass

  logic                        clk            = 1'b0;
  logic                        rst            = 1'b1;
  logic                        cfg_write      = 1'b0;
  cnms_pkg::reg_idx_t          cfg_index      = cnms_pkg::REG_IMAGE_WIDTH;
  logic [cnms_pkg::CFG_W-1:0]  cfg_data       = '0;
  logic                        push           = 1'b0;
  logic                        full;
  logic                        start_of_frame = 1'b0;
  logic [cnms_pkg::MAG_W-1:0]  grad_mag       = '0;
  logic [cnms_pkg::GRAD_W-1:0] grad_x         = '0;
  logic [cnms_pkg::GRAD_W-1:0] grad_y         = '0;
  logic                        empty;
  logic                        pop            = 1'b0;
  logic [cnms_pkg::MAG_W-1:0]  out_mag;
  logic                        suppressed;

  nms_scoreboard sb;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int quiet_cycles  = 0;
  int pixels_sent   = 0;
  int settings_seen = 0;

  canny_nonmax_suppression #(.MAX_WIDTH(LINE_MAX)) uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full),
    .start_of_frame(start_of_frame), .grad_mag(grad_mag),
    .grad_x(grad_x), .grad_y(grad_y),
    .empty(empty), .pop(pop),
    .out_mag(out_mag), .suppressed(suppressed)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    pop <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_result(out_mag, suppressed);
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one request per call, held until the block takes it
  task automatic send_pixel(input logic sof, input logic [cnms_pkg::MAG_W-1:0] mag,
                            input logic [cnms_pkg::GRAD_W-1:0] gx,
                            input logic [cnms_pkg::GRAD_W-1:0] gy);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push           <= 1'b1;
    start_of_frame <= sof;
    grad_mag       <= mag;
    grad_x         <= gx;
    grad_y         <= gy;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_pixel(sof, mag, gx, gy);
    pixels_sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // a pixel that gives no result may still be in flight after the last result
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cnms_pkg::reg_idx_t idx, input int unsigned val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= cnms_pkg::CFG_W'(val);
    @(posedge clk);
    sb.set_reg(idx, cnms_pkg::CFG_W'(val));
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input int unsigned w, input int unsigned thr);
    write_reg(cnms_pkg::REG_IMAGE_WIDTH, w);
    write_reg(cnms_pkg::REG_LOW_THRESHOLD, thr);
    settings_seen++;
  endtask

  function automatic logic [cnms_pkg::MAG_W-1:0] rand_mag(input int unsigned thr);
    int v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 32767);
      1: begin
        v = int'(thr) + int'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        if (v > 32767) v = 32767;
      end
      2: v = $urandom_range(0, 15);
      3: v = $urandom_range(0, 1) ? 32767 : 0;
      default: v = $urandom_range(0, 1023);
    endcase
    return cnms_pkg::MAG_W'(v);
  endfunction

  function automatic logic [cnms_pkg::GRAD_W-1:0] rand_grad();
    case ($urandom_range(0, 4))
      0, 1: return cnms_pkg::GRAD_W'($urandom);
      2: return cnms_pkg::GRAD_W'($urandom_range(0, 8) - 4);
      3: return '0;
      default: return $urandom_range(0, 1) ? 15'h3FFF : 15'h4000;
    endcase
  endfunction

  // width 3, centres in the middle column cover each direction, ties,
  // magnitudes at and around the threshold and the field extremes
  task automatic run_directed();
    int m[24];
    int gx[8];
    int gy[8];
    m  = '{0, 32767, 5,   200, 300, 300,      50, 100, 32767,  32767, 101, 0,
           7, 99, 7,      32767, 32767, 32767, 0, 500, 1000,   400, 600, 0};
    gx = '{-16384, 16383, 0, -16384, 16383, 0, -16384, 5};
    gy = '{-16384, 0, -16384, 16383, 16383, 0, -16384, -3};
    set_regs(3, 100);
    send_idle_pct = 0;
    stall_pct     = 0;
    for (int i = 0; i < 24; i++) begin
      send_pixel(i == 0, cnms_pkg::MAG_W'(m[i]),
                 (i % 3 == 1) ? cnms_pkg::GRAD_W'(gx[i / 3]) : rand_grad(),
                 (i % 3 == 1) ? cnms_pkg::GRAD_W'(gy[i / 3]) : rand_grad());
    end
  endtask

  task automatic run_phase(input int unsigned w, input int unsigned thr,
                           input int send_pct, input int stall_p, input int unsigned n);
    int unsigned len;
    int unsigned px;
    int unsigned sent;
    bit          first;
    settle();
    set_regs(w, thr);
    send_idle_pct = send_pct;
    stall_pct     = stall_p;
    len   = (w < 3) ? 3 : ((w > LINE_MAX) ? LINE_MAX : w);
    sent  = 0;
    first = 1'b1;
    while (sent < n) begin
      px = $urandom_range(3, 6) * len;
      // broken frame: cut short, the next one restarts the counters if it starts with start_of_frame
      if (len <= 64 && $urandom_range(0, 9) == 0) px = $urandom_range(1, px);
      for (int i = 0; i < px && sent < n; i++) begin
        send_pixel(i == 0 && (first || $urandom_range(0, 5) != 0), rand_mag(thr),
                   rand_grad(), rand_grad());
        sent++;
      end
      first = 1'b0;
      if ($urandom_range(0, 7) == 0) drain();
    end
  endtask

  // narrow the row while the column count is already past the new width
  task automatic run_shrink();
    settle();
    set_regs(10, 50);
    send_idle_pct = 0;
    stall_pct     = 55;
    for (int i = 0; i < 38; i++) send_pixel(i == 0, rand_mag(50), rand_grad(), rand_grad());
    settle();
    set_regs(6, 50);
    for (int i = 0; i < 26; i++) send_pixel(1'b0, rand_mag(50), rand_grad(), rand_grad());
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_phase(5, 1, 0, 0, 130);
    run_phase(1, 32767, 55, 0, 60);
    run_phase(8, 300, 0, 55, 130);
    run_phase(12, 20, 23, 23, 130);
    run_shrink();
    run_phase(3, 1000, 0, 0, 80);
    run_phase(17, 16384, 55, 0, 80);
    run_phase(2048, 100, 23, 23, 20);
    run_phase(4095, 1, 0, 0, 20);
    run_phase(6, 1, 0, 55, 80);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending());
      sb.errors++;
    end
    $display("%0d pixels over %0d register settings, widths 1 to 4095, thresholds 1 to 32767",
             pixels_sent, settings_seen);
    $display("%0d results checked, %0d suppressed, %0d mismatches",
             sb.checked, sb.zeroed, sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
